[hw/rtl/bir_pkg.sv]
// bir_pkg: constants, state type and helper functions for the bilinear resize core
// no dependencies; compile first

package bir_pkg;

  // frame limits and pixel format
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int PIX_W       = 16;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);

  // register widths
  localparam int SIZE_W     = 9;
  localparam int SCALE_W    = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  // fixed point
  localparam int FRAC_W  = 16;
  localparam int ONE_Q   = 1 << FRAC_W;
  localparam int MAP_W   = COL_W + 1 + SCALE_W;
  localparam int POS_W   = COL_W + FRAC_W;
  localparam int HORZ_W  = PIX_W + FRAC_W + 2;
  localparam int BLEND_W = PIX_W + 2 * FRAC_W + 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_W   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_W   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_H   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 3'd5;

  // input action codes
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  // request sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_CLAMP,
    ST_BASE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RDW,
    ST_HORZ,
    ST_VERT,
    ST_DONE
  } state_e;

  // zero acts as one, anything above the limit acts as the limit
  function automatic logic [SIZE_W-1:0] fit_size(input logic [SIZE_W-1:0] v,
                                                 input int maxv);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (v > SIZE_W'(maxv)) begin
      res = SIZE_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

[hw/rtl/bir_if.sv]
// bir_in_if / bir_out_if: valid-ready channels of the bilinear resize core
// depends on bir_pkg for payload widths

interface bir_in_if;
  import bir_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, action, pixel, input ready);
  modport sink (input valid, action, pixel, output ready);
endinterface

interface bir_out_if;
  import bir_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] value;
  logic             last;

  modport source (output valid, value, last, input ready);
  modport sink (input valid, value, last, output ready);
endinterface

[hw/rtl/bir_ram.sv]
// bir_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module bir_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hw/rtl/bilinear_image_resize_core.sv]
// bilinear_image_resize_core: bilinear frame resize with half-pixel centers, Q16 math
// depends on bir_pkg, bir_in_if / bir_out_if and bir_ram
//
// channel  dir  payload         word meaning
// in_i     in   action, pixel   load one source pixel or request one target pixel
// out_o    out  value, last     one interpolated target pixel per request
// cfg      in   we, idx, data   register write, no read-back
//
// a load word is written to the frame ram in the cycle it is accepted, so loads
// stream at one word per cycle while no request is in flight. a request word
// runs through a sequence (map, clamp, row base, four reads on the single ram
// read port, two blend multiplies, round); the next word is taken once the result
// sits in the output register. reset clears sequencer, counters, config, valid and
// last, not frame ram or datapath. a stalled output holds the sequence's last step.

module bilinear_image_resize_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bir_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bir_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  bir_in_if.sink                            in_i,
  bir_out_if.source                         out_o
);
  import bir_pkg::*;

  // configuration registers
  logic [SIZE_W-1:0]  src_w_q, src_h_q, dst_w_q, dst_h_q;
  logic [SCALE_W-1:0] scale_x_q, scale_y_q;

  // effective sizes
  logic [SIZE_W-1:0] sw, sh, tw, th;

  // sequencer and counters
  state_e            state_q, state_d;
  logic [ADDR_W-1:0] load_idx_q, load_idx_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              out_valid_q, out_valid_d;
  logic [PIX_W-1:0]  value_q, value_d;
  logic              last_q, last_d;

  // datapath registers
  logic [MAP_W-1:0]          vx_q, vy_q;
  logic [COL_W-1:0]          x0_q;
  logic [ROW_W-1:0]          y0_q;
  logic [FRAC_W-1:0]         fx_q, fy_q;
  logic                      pass_q;
  logic [ADDR_W-1:0]         a00_q;
  logic                      x_step_q, y_step_q;
  logic [PIX_W-1:0]          pix_q [4];
  logic signed [HORZ_W-1:0]  top_q, bot_q;
  logic signed [BLEND_W-1:0] prod_q;

  // handshake and ram control
  logic              in_fire, load_fire, req_fire, out_free;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [PIX_W-1:0]  ram_rdata;
  logic [ADDR_W-1:0] row_off;
  logic [ADDR_W:0]   load_count, load_next;

  // clamped combinational values
  logic [POS_W-1:0]          px, py;
  logic [SIZE_W-1:0]         cc, rc;
  logic signed [PIX_W:0]     dt, db;
  logic signed [HORZ_W-1:0]  top_d, bot_d, diff;
  logic signed [BLEND_W-1:0] prod_d, blend, rounded;
  logic [SIZE_W-1:0]         col_inc, row_inc;
  logic                      frame_last;

  // source position for target coordinate, clamped to [0, (n-1) << 16]
  function automatic logic [POS_W-1:0] clamp_pos(input logic [MAP_W-1:0]  v,
                                                 input logic [SIZE_W-1:0] n);
    logic [MAP_W-1:0] p;
    logic [MAP_W-1:0] hi;
    hi = MAP_W'(n - SIZE_W'(1)) << FRAC_W;
    if (v < MAP_W'(ONE_Q)) begin
      p = '0;
    end else begin
      p = (v - MAP_W'(ONE_Q)) >> 1;
    end
    if (p > hi) begin
      p = hi;
    end
    return p[POS_W-1:0];
  endfunction

  assign sw = fit_size(src_w_q, MAX_WIDTH);
  assign sh = fit_size(src_h_q, MAX_HEIGHT);
  assign tw = fit_size(dst_w_q, MAX_WIDTH);
  assign th = fit_size(dst_h_q, MAX_HEIGHT);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q   <= SIZE_W'(256);
      src_h_q   <= SIZE_W'(256);
      dst_w_q   <= SIZE_W'(256);
      dst_h_q   <= SIZE_W'(256);
      scale_x_q <= SCALE_W'(ONE_Q);
      scale_y_q <= SCALE_W'(ONE_Q);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SRC_W:   src_w_q   <= cfg_data_i[SIZE_W-1:0];
        REG_SRC_H:   src_h_q   <= cfg_data_i[SIZE_W-1:0];
        REG_DST_W:   dst_w_q   <= cfg_data_i[SIZE_W-1:0];
        REG_DST_H:   dst_h_q   <= cfg_data_i[SIZE_W-1:0];
        REG_SCALE_X: scale_x_q <= cfg_data_i[SCALE_W-1:0];
        REG_SCALE_Y: scale_y_q <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign load_fire  = in_fire && (in_i.action == ACT_LOAD);
  assign req_fire   = in_fire && (in_i.action == ACT_REQUEST);
  assign out_free   = !out_valid_q || out_o.ready;

  // load index wraps at the end of the source frame
  assign load_count = (ADDR_W + 1)'(sw) * (ADDR_W + 1)'(sh);
  assign load_next  = (ADDR_W + 1)'(load_idx_q) + (ADDR_W + 1)'(1);

  // frame memory
  bir_ram #(
    .Width (PIX_W),
    .Depth (STORE_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (load_fire),
    .waddr_i (load_idx_q),
    .wdata_i (in_i.pixel),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // neighbor addresses
  assign row_off = y_step_q ? ADDR_W'(sw) : '0;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = a00_q;
    case (state_q)
      ST_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = a00_q;
      end
      ST_RD1: begin
        ram_re    = 1'b1;
        ram_raddr = a00_q + ADDR_W'(x_step_q);
      end
      ST_RD2: begin
        ram_re    = 1'b1;
        ram_raddr = a00_q + row_off;
      end
      ST_RD3: begin
        ram_re    = 1'b1;
        ram_raddr = a00_q + row_off + ADDR_W'(x_step_q);
      end
      default: ;
    endcase
  end

  // clamp stage, equal sizes pass the stored pixel through
  assign px = clamp_pos(vx_q, sw);
  assign py = clamp_pos(vy_q, sh);
  assign cc = (SIZE_W'(col_q) < sw) ? SIZE_W'(col_q) : sw - SIZE_W'(1);
  assign rc = (SIZE_W'(row_q) < sh) ? SIZE_W'(row_q) : sh - SIZE_W'(1);

  // horizontal blend
  assign dt    = $signed({1'b0, pix_q[1]}) - $signed({1'b0, pix_q[0]});
  assign db    = $signed({1'b0, pix_q[3]}) - $signed({1'b0, pix_q[2]});
  assign top_d = $signed({2'b00, pix_q[0], FRAC_W'(0)}) + $signed({1'b0, fx_q}) * dt;
  assign bot_d = $signed({2'b00, pix_q[2], FRAC_W'(0)}) + $signed({1'b0, fx_q}) * db;

  // vertical blend and round half up
  assign diff    = bot_q - top_q;
  assign prod_d  = $signed({1'b0, fy_q}) * diff;
  assign blend   = (BLEND_W'(top_q) <<< FRAC_W) + prod_q;
  assign rounded = blend[BLEND_W-1] ? '0 : blend + (BLEND_W'(1) <<< (2 * FRAC_W - 1));

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_MAP: begin
        vx_q <= MAP_W'({col_q, 1'b1}) * MAP_W'(scale_x_q);
        vy_q <= MAP_W'({row_q, 1'b1}) * MAP_W'(scale_y_q);
      end
      ST_CLAMP: begin
        pass_q <= (sw == tw) && (sh == th);
        if ((sw == tw) && (sh == th)) begin
          x0_q <= cc[COL_W-1:0];
          y0_q <= rc[ROW_W-1:0];
          fx_q <= '0;
          fy_q <= '0;
        end else begin
          x0_q <= px[POS_W-1:FRAC_W];
          y0_q <= py[POS_W-1:FRAC_W];
          fx_q <= px[FRAC_W-1:0];
          fy_q <= py[FRAC_W-1:0];
        end
      end
      ST_BASE: begin
        a00_q    <= ADDR_W'(ADDR_W'(y0_q) * ADDR_W'(sw)) + ADDR_W'(x0_q);
        x_step_q <= !pass_q && (SIZE_W'(x0_q) + SIZE_W'(1) < sw);
        y_step_q <= !pass_q && (SIZE_W'(y0_q) + SIZE_W'(1) < sh);
      end
      ST_RD1:  pix_q[0] <= ram_rdata;
      ST_RD2:  pix_q[1] <= ram_rdata;
      ST_RD3:  pix_q[2] <= ram_rdata;
      ST_RDW:  pix_q[3] <= ram_rdata;
      ST_HORZ: begin
        top_q <= top_d;
        bot_q <= bot_d;
      end
      ST_VERT: prod_q <= prod_d;
      default: ;
    endcase
  end

  // target counters advance once a result is committed
  assign col_inc    = SIZE_W'(col_q) + SIZE_W'(1);
  assign row_inc    = SIZE_W'(row_q) + SIZE_W'(1);
  assign frame_last = (SIZE_W'(col_q) == tw - SIZE_W'(1)) &&
                      (SIZE_W'(row_q) == th - SIZE_W'(1));

  // next state and control
  always_comb begin
    state_d     = state_q;
    load_idx_d  = load_idx_q;
    col_d       = col_q;
    row_d       = row_q;
    out_valid_d = out_valid_q;
    value_d     = value_q;
    last_d      = last_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (load_fire) begin
          load_idx_d = (load_next >= load_count) ? '0 : load_next[ADDR_W-1:0];
        end
        if (req_fire) begin
          state_d = ST_MAP;
        end
      end
      ST_MAP:   state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_BASE;
      ST_BASE:  state_d = ST_RD0;
      ST_RD0:   state_d = ST_RD1;
      ST_RD1:   state_d = ST_RD2;
      ST_RD2:   state_d = ST_RD3;
      ST_RD3:   state_d = ST_RDW;
      ST_RDW:   state_d = ST_HORZ;
      ST_HORZ:  state_d = ST_VERT;
      ST_VERT:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          value_d     = rounded[PIX_W+2*FRAC_W-1:2*FRAC_W];
          last_d      = frame_last;
          state_d     = ST_IDLE;
          if (col_inc >= tw) begin
            col_d = '0;
            row_d = (row_inc >= th) ? '0 : row_inc[ROW_W-1:0];
          end else begin
            col_d = col_inc[COL_W-1:0];
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      load_idx_q  <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      load_idx_q  <= load_idx_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.value = value_q;
  assign out_o.last  = last_q;

endmodule

[tb/tb_top.sv]
// tb_top: self-checking testbench for bilinear_image_resize_core, loads frames and checks
// every interpolated pixel against an in-bench predictor; depends on bir_pkg and bir_if

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bir_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 32;
  localparam int RANDOM_ITEMS = 2000;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    logic             action;
    logic [PIX_W-1:0] pixel;
    bit               hold;
  } in_word_t;

  typedef struct {
    logic [PIX_W-1:0] value;
    logic             last;
  } pix_word_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  bir_in_if  in_ch ();
  bir_out_if out_ch ();

  bilinear_image_resize_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch.sink),
    .out_o      (out_ch.source)
  );

  // stimulus and expectation stores
  in_word_t  pending_q [$];
  pix_word_t pix_exp_q [$];
  in_word_t  drv_word;
  pix_word_t got_word;
  pix_word_t exp_word;

  int err_count   = 0;
  int cycle_count = 0;
  int sent_words  = 0;
  int send_idle_pct;
  int recv_idle_pct;

  // predictor state: register copies, frame store and counters
  logic [SIZE_W-1:0]  reg_src_w, reg_src_h, reg_dst_w, reg_dst_h;
  logic [SCALE_W-1:0] reg_scale_x, reg_scale_y;
  logic [PIX_W-1:0]   frame_mem [STORE_DEPTH];
  int                 load_ptr;
  int                 col_ctr;
  int                 row_ctr;

  // stimulus planning: which store entries will have been written
  bit loaded [STORE_DEPTH];
  int plan_ptr;
  int loaded_prefix;

  always #1 clk_i = ~clk_i;

  // size register as the block sees it
  function automatic int eff_size(input logic [SIZE_W-1:0] v, input int limit);
    int res;
    if (v == '0) begin
      res = 1;
    end else if (int'(v) > limit) begin
      res = limit;
    end else begin
      res = int'(v);
    end
    return res;
  endfunction

  // half-pixel mapping of a target coordinate to a clamped Q16 source position
  function automatic longint src_pos(input int t, input logic [SCALE_W-1:0] scale,
                                     input int n);
    longint p;
    longint hi;
    p  = (longint'(2 * t + 1) * longint'(scale) - 64'sd65536) / 2;
    hi = longint'(n - 1) << 16;
    if (p < 0) p = 0;
    if (p > hi) p = hi;
    return p;
  endfunction

  function automatic longint pix_at(input int r, input int c, input int w);
    int addr;
    addr = r * w + c;
    if (addr >= STORE_DEPTH) return 0;
    return longint'(frame_mem[addr]);
  endfunction

  // one accepted word: store a pixel or compute the next target pixel
  task automatic resize_step(input logic act, input logic [PIX_W-1:0] pix);
    int        sw, sh, tw, th, x0, x1, y0, y1, c, r;
    longint    px, py, fx, fy, p00, p01, p10, p11, top, bot, blend, rounded;
    pix_word_t res;
    sw = eff_size(reg_src_w, MAX_WIDTH);
    sh = eff_size(reg_src_h, MAX_HEIGHT);
    tw = eff_size(reg_dst_w, MAX_WIDTH);
    th = eff_size(reg_dst_h, MAX_HEIGHT);
    if (act == ACT_LOAD) begin
      if (load_ptr < STORE_DEPTH) frame_mem[load_ptr] = pix;
      load_ptr = (load_ptr + 1 >= sw * sh) ? 0 : load_ptr + 1;
    end else begin
      if (sw == tw && sh == th) begin
        // equal sizes pass the stored pixel through
        c = (col_ctr < sw) ? col_ctr : sw - 1;
        r = (row_ctr < sh) ? row_ctr : sh - 1;
        res.value = PIX_W'(pix_at(r, c, sw));
      end else begin
        px  = src_pos(col_ctr, reg_scale_x, sw);
        py  = src_pos(row_ctr, reg_scale_y, sh);
        x0  = int'(px >> 16);
        y0  = int'(py >> 16);
        fx  = px & 64'hffff;
        fy  = py & 64'hffff;
        x1  = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
        y1  = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
        p00 = pix_at(y0, x0, sw);
        p01 = pix_at(y0, x1, sw);
        p10 = pix_at(y1, x0, sw);
        p11 = pix_at(y1, x1, sw);
        top = p00 * 65536 + fx * (p01 - p00);
        bot = p10 * 65536 + fx * (p11 - p10);
        blend = top * 65536 + fy * (bot - top);
        if (blend < 0) blend = 0;
        rounded = (blend + 64'sh8000_0000) >> 32;
        res.value = rounded[PIX_W-1:0];
      end
      res.last = (col_ctr == tw - 1) && (row_ctr == th - 1);
      col_ctr++;
      if (col_ctr >= tw) begin
        col_ctr = 0;
        row_ctr++;
        if (row_ctr >= th) row_ctr = 0;
      end
      pix_exp_q.push_back(res);
    end
  endtask

  // driver: present pending words, random gaps, optional hold until drained
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) resize_step(in_ch.action, in_ch.pixel);
      if (pending_q.size() != 0 && (!pending_q[0].hold || pix_exp_q.size() == 0) &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        drv_word = pending_q.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.action <= drv_word.action;
        in_ch.pixel  <= drv_word.pixel;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: random back-pressure, compare each word with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_word.value = out_ch.value;
        got_word.last  = out_ch.last;
        if (pix_exp_q.size() == 0) begin
          if (err_count < MAX_REPORTS)
            $display("%0t: unexpected word, value %h last %b", $time,
                     got_word.value, got_word.last);
          err_count++;
        end else begin
          exp_word = pix_exp_q.pop_front();
          if (got_word.value !== exp_word.value) begin
            if (err_count < MAX_REPORTS)
              $display("%0t: value mismatch, expected %h, actual %h", $time,
                       exp_word.value, got_word.value);
            err_count++;
          end
          if (got_word.last !== exp_word.last) begin
            if (err_count < MAX_REPORTS)
              $display("%0t: last mismatch, expected %b, actual %b", $time,
                       exp_word.last, got_word.last);
            err_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("bilinear_image_resize_core regression: fail");
      $finish;
    end
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return PIX_W'($urandom);
  endfunction

  function automatic int frame_count();
    return eff_size(reg_src_w, MAX_WIDTH) * eff_size(reg_src_h, MAX_HEIGHT);
  endfunction

  // queue a load and track which store entries it will fill
  task automatic queue_load(input logic [PIX_W-1:0] pix, input bit hold);
    in_word_t w;
    w.action = ACT_LOAD;
    w.pixel  = pix;
    w.hold   = hold;
    pending_q.push_back(w);
    sent_words++;
    if (plan_ptr < STORE_DEPTH) loaded[plan_ptr] = 1'b1;
    plan_ptr = (plan_ptr + 1 >= frame_count()) ? 0 : plan_ptr + 1;
    while (loaded_prefix < STORE_DEPTH && loaded[loaded_prefix]) loaded_prefix++;
  endtask

  task automatic queue_request(input bit hold);
    in_word_t w;
    w.action = ACT_REQUEST;
    w.pixel  = PIX_W'($urandom);
    w.hold   = hold;
    pending_q.push_back(w);
    sent_words++;
  endtask

  // one full source frame; a stale pointer past the frame costs one extra load
  task automatic fill_frame();
    int n;
    n = (plan_ptr < frame_count()) ? frame_count() : frame_count() + 1;
    repeat (n) queue_load(rand_pixel(), 1'b0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      REG_SRC_W:   reg_src_w   = data[SIZE_W-1:0];
      REG_SRC_H:   reg_src_h   = data[SIZE_W-1:0];
      REG_DST_W:   reg_dst_w   = data[SIZE_W-1:0];
      REG_DST_H:   reg_dst_h   = data[SIZE_W-1:0];
      REG_SCALE_X: reg_scale_x = data[SCALE_W-1:0];
      REG_SCALE_Y: reg_scale_y = data[SCALE_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // everything accepted and answered, then let the sequencer settle
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_q.size() != 0 || in_ch.valid || pix_exp_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // reconfigure while idle, make the frame readable, then a mix of words
  task automatic run_phase(input int sw, input int sh, input int tw, input int th,
                           input int sx, input int sy, input int n_words,
                           input int load_pct, input bit refill, input int hold_at);
    int k;
    wait_idle();
    write_reg(REG_SRC_W, CFG_DATA_W'(sw));
    write_reg(REG_SRC_H, CFG_DATA_W'(sh));
    write_reg(REG_DST_W, CFG_DATA_W'(tw));
    write_reg(REG_DST_H, CFG_DATA_W'(th));
    write_reg(REG_SCALE_X, CFG_DATA_W'(sx));
    write_reg(REG_SCALE_Y, CFG_DATA_W'(sy));
    if (refill || loaded_prefix < frame_count()) fill_frame();
    for (k = 0; k < n_words; k++) begin
      if ($urandom_range(0, 99) < load_pct) queue_load(rand_pixel(), k == hold_at);
      else queue_request(k == hold_at);
    end
  endtask

  function automatic int pick_size(input int small_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 12) return $urandom_range(257, 511);
    if (r < 16) return 256;
    return $urandom_range(1, small_max);
  endfunction

  function automatic int pick_scale(input int s_raw, input int t_raw, input int limit);
    int r, ideal;
    ideal = (eff_size(SIZE_W'(s_raw), limit) << 16) / eff_size(SIZE_W'(t_raw), limit);
    r = $urandom_range(0, 99);
    if (r < 60) return ideal;
    if (r < 75) return (ideal + $urandom_range(0, 64) > 32) ?
                       ideal + $urandom_range(0, 64) - 32 : ideal;
    if (r < 88) return $urandom_range(0, 16777216);
    if (r < 94) return 0;
    return 16777216;
  endfunction

  initial begin
    int phase_no;
    int sw, sh, tw, th, n;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_LOAD;
    in_ch.pixel   = '0;
    out_ch.ready  = 1'b0;
    send_idle_pct = 26;
    recv_idle_pct = 51;
    reg_src_w     = SIZE_W'(256);
    reg_src_h     = SIZE_W'(256);
    reg_dst_w     = SIZE_W'(256);
    reg_dst_h     = SIZE_W'(256);
    reg_scale_x   = SCALE_W'(65536);
    reg_scale_y   = SCALE_W'(65536);
    load_ptr      = 0;
    col_ctr       = 0;
    row_ctr       = 0;
    plan_ptr      = 0;
    loaded_prefix = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset sizes pass through; only the first entries are read
    queue_load(16'h0000, 1'b0);
    queue_load(16'hffff, 1'b0);
    queue_load(16'h8000, 1'b0);
    queue_load(16'h7fff, 1'b0);
    repeat (3) queue_request(1'b0);
    // 2x2 up to 3x3, nine requests reaching the last pixel, one drain pause
    run_phase(2, 2, 3, 3, 'haaaa, 'haaaa, 9, 0, 1'b0, 4);
    // zero source sizes act as one, oversize target acts as the limit
    run_phase(0, 0, 300, 2, 16777216, 0, 5, 0, 1'b0, -1);
    // equal sizes with the counter past the new frame
    run_phase(1, 1, 0, 0, 12345, 16777216, 2, 0, 1'b0, -1);

    phase_no = 0;
    while (sent_words < RANDOM_ITEMS) begin
      if (sent_words < RANDOM_ITEMS / 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 51;
      end else if (sent_words < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 51;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase_no == 2) begin
        // one full-width frame, oversize width, downscaled in width and upscaled in height
        n = 40;
        run_phase(400, 2, 80, 3, (256 << 16) / 80, (2 << 16) / 3, n, 10, 1'b1, 20);
      end else begin
        sw = pick_size(12);
        sh = pick_size(12);
        // keep the source frame to a few hundred pixels
        if (eff_size(SIZE_W'(sw), MAX_WIDTH) * eff_size(SIZE_W'(sh), MAX_HEIGHT) > 600)
        begin
          if (eff_size(SIZE_W'(sw), MAX_WIDTH) > 16) sh = $urandom_range(1, 2);
          else sw = $urandom_range(1, 2);
        end
        if ($urandom_range(0, 99) < 30) begin
          tw = sw;
          th = sh;
        end else begin
          tw = pick_size(20);
          th = pick_size(20);
          if (eff_size(SIZE_W'(tw), MAX_WIDTH) > 20 &&
              eff_size(SIZE_W'(th), MAX_HEIGHT) > 20)
            th = $urandom_range(1, 20);
        end
        n = $urandom_range(20, 120);
        run_phase(sw, sh, tw, th, pick_scale(sw, tw, MAX_WIDTH),
                  pick_scale(sh, th, MAX_HEIGHT), n, 20, $urandom_range(0, 1),
                  ($urandom_range(0, 99) < 25) ? $urandom_range(1, n - 1) : -1);
      end
      phase_no++;
    end

    wait_idle();
    if (pix_exp_q.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("bilinear_image_resize_core regression: pass");
    end else begin
      $display("bilinear_image_resize_core regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/bir_pkg.sv
hw/rtl/bir_if.sv
hw/rtl/bir_ram.sv
hw/rtl/bilinear_image_resize_core.sv
tb/tb_top.sv
